// ----- src/texture_alpha_blit_assert.svh -----
// assertion macros for the texture blit checker
// expects clk_i and rst_ni in the scope of use
`ifndef TEXTURE_ALPHA_BLIT_ASSERT_SVH
`define TEXTURE_ALPHA_BLIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TAB_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define TAB_ASSERT_NX(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tab_pkg.sv -----
// shared types and constants for the texture alpha blit
// no dependencies
`default_nettype none

package tab_pkg;

  // default frame buffer address width
  localparam int unsigned ADDR_BITS_DEF = 24;
  // output address field width
  localparam int unsigned FB_ADDR_W = 24;
  // queue depth between front and back
  localparam int unsigned QDEPTH = 2;
  // largest texture side
  localparam logic [12:0] TEX_MAX = 13'd4096;

  // configuration register indexes
  localparam logic [2:0] CFG_FB_WIDTH = 3'd0;
  localparam logic [2:0] CFG_TEX_X    = 3'd1;
  localparam logic [2:0] CFG_TEX_Y    = 3'd2;
  localparam logic [2:0] CFG_TEX_W    = 3'd3;
  localparam logic [2:0] CFG_TEX_H    = 3'd4;

  // reset values
  localparam logic [12:0] FB_WIDTH_RST = 13'd1024;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  // pixel class decided by the front
  typedef enum logic [1:0] {
    PIX_SKIP,
    PIX_COPY,
    PIX_BLEND
  } pix_kind_e;

  typedef struct packed {
    logic [12:0] fb_width;
    logic [11:0] tex_x;
    logic [11:0] tex_y;
    logic [12:0] tex_w;
    logic [12:0] tex_h;
  } cfg_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    pix_kind_e   kind;
    logic        last;
    logic [12:0] line;
    logic [12:0] colx;
  } blit_entry_t;

endpackage

`default_nettype wire

// ----- src/tab_front.sv -----
// front end: walks the rectangle, classifies each pixel, forms address operands
// depends on tab_pkg
`default_nettype none

module tab_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tab_pkg::cfg_t       cfg_i,
  input  wire logic                push_i,
  input  wire logic [31:0]         src_pixel_i,
  input  wire logic [31:0]         dst_pixel_i,
  output tab_pkg::blit_entry_t     entry_o
);

  logic [11:0] column_q, column_d;
  logic [11:0] row_q, row_d;
  logic [12:0] w_eff, h_eff;
  logic [11:0] w_last, h_last;
  logic        end_col, end_row;
  logic [7:0]  alpha;

  // clamp texture size to 1..4096
  always_comb begin
    if (cfg_i.tex_w == 13'd0) begin
      w_eff = 13'd1;
    end else if (cfg_i.tex_w > tab_pkg::TEX_MAX) begin
      w_eff = tab_pkg::TEX_MAX;
    end else begin
      w_eff = cfg_i.tex_w;
    end
    if (cfg_i.tex_h == 13'd0) begin
      h_eff = 13'd1;
    end else if (cfg_i.tex_h > tab_pkg::TEX_MAX) begin
      h_eff = tab_pkg::TEX_MAX;
    end else begin
      h_eff = cfg_i.tex_h;
    end
  end

  assign w_last  = 12'(w_eff - 13'd1);
  assign h_last  = 12'(h_eff - 13'd1);
  assign end_col = column_q >= w_last;
  assign end_row = row_q >= h_last;

  // next counter position
  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (push_i) begin
      if (end_col) begin
        column_d = 12'd0;
        row_d    = end_row ? 12'd0 : row_q + 12'd1;
      end else begin
        column_d = column_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= 12'd0;
      row_q    <= 12'd0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  // classification and operands
  assign alpha = src_pixel_i[31:24];

  always_comb begin
    entry_o.src  = src_pixel_i;
    entry_o.dst  = dst_pixel_i;
    entry_o.last = end_col && end_row;
    entry_o.line = {1'b0, cfg_i.tex_y} + {1'b0, row_q};
    entry_o.colx = {1'b0, cfg_i.tex_x} + {1'b0, column_q};
    if (alpha == 8'd0) begin
      entry_o.kind = tab_pkg::PIX_SKIP;
    end else if (alpha == tab_pkg::ALPHA_FULL) begin
      entry_o.kind = tab_pkg::PIX_COPY;
    end else begin
      entry_o.kind = tab_pkg::PIX_BLEND;
    end
  end

endmodule

`default_nettype wire

// ----- src/tab_queue.sv -----
// short queue between front and back
// depends on tab_pkg
`default_nettype none

module tab_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tab_pkg::blit_entry_t wr_entry_i,
  input  wire logic                pop_i,
  output tab_pkg::blit_entry_t     rd_entry_o,
  output logic                     full_o,
  output logic                     not_empty_o
);

  localparam int unsigned PtrW = (tab_pkg::QDEPTH > 1) ? $clog2(tab_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(tab_pkg::QDEPTH + 1);

  tab_pkg::blit_entry_t mem_q [tab_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o      = count_q == CntW'(tab_pkg::QDEPTH);
  assign not_empty_o = count_q != '0;
  assign rd_entry_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(tab_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(tab_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/tab_back.sv -----
// back end: blend arithmetic, address multiply-add, output register
// depends on tab_pkg
`default_nettype none

module tab_back #(
  parameter int unsigned ADDR_BITS = tab_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [12:0]          fb_width_i,
  input  wire logic                 head_valid_i,
  input  wire tab_pkg::blit_entry_t head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [tab_pkg::FB_ADDR_W-1:0] fb_address_o,
  output logic                      write_enable_o,
  output logic [31:0]               color_o,
  output logic                      last_o
);

  logic        adv;
  logic        a_valid_q;
  logic [25:0] a_prod_q;
  logic [12:0] a_colx_q;
  logic [15:0] a_sum_q [3];
  logic [31:0] a_src_q;
  tab_pkg::pix_kind_e a_kind_q;
  logic        a_last_q;

  logic [7:0]  alpha, alpha_inv;
  logic [15:0] sum_d [3];
  logic [7:0]  quot [3];
  logic [26:0] addr_full;
  logic [tab_pkg::FB_ADDR_W-1:0] addr_mask;
  logic [31:0] color_d;

  // pipeline moves when the output slot is free or being taken
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  // channel products: s*a + d*(255-a)
  assign alpha     = head_i.src[31:24];
  assign alpha_inv = tab_pkg::ALPHA_FULL - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = {8'd0, head_i.src[8*c +: 8]} * {8'd0, alpha}
               + {8'd0, head_i.dst[8*c +: 8]} * {8'd0, alpha_inv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_prod_q <= {13'd0, head_i.line} * {13'd0, fb_width_i};
      a_colx_q <= head_i.colx;
      a_src_q  <= head_i.src;
      a_kind_q <= head_i.kind;
      a_last_q <= head_i.last;
      for (int c = 0; c < 3; c++) begin
        a_sum_q[c] <= sum_d[c];
      end
    end
  end

  // divide by 255: (x + 1 + (x >> 8)) >> 8, exact for sums up to 255*255
  always_comb begin
    logic [16:0] t;
    for (int c = 0; c < 3; c++) begin
      t = {1'b0, a_sum_q[c]} + 17'd1 + {9'd0, a_sum_q[c][15:8]};
      quot[c] = t[15:8];
    end
  end

  // address add and wrap to ADDR_BITS
  assign addr_full = {1'b0, a_prod_q} + {14'd0, a_colx_q};

  always_comb begin
    for (int i = 0; i < int'(tab_pkg::FB_ADDR_W); i++) begin
      addr_mask[i] = (i < int'(ADDR_BITS)) ? addr_full[i] : 1'b0;
    end
  end

  // colour select by pixel class
  always_comb begin
    case (a_kind_q)
      tab_pkg::PIX_SKIP:  color_d = 32'd0;
      tab_pkg::PIX_COPY:  color_d = a_src_q;
      tab_pkg::PIX_BLEND: color_d = {tab_pkg::ALPHA_FULL, quot[2], quot[1], quot[0]};
      default:            color_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fb_address_o   <= addr_mask;
      write_enable_o <= a_kind_q != tab_pkg::PIX_SKIP;
      color_o        <= color_d;
      last_o         <= a_last_q;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= head_valid_i;
      out_valid_o <= a_valid_q;
    end
  end

endmodule

`default_nettype wire

// ----- src/texture_alpha_blit.sv -----
// Texture alpha blit: composites a texture rectangle into a frame buffer,
// source over destination, one ARGB8888 pixel per transfer in raster order.
// One pixel is taken every clock cycle in steady state; a pixel's write
// request passes the queue, the blend multiply stage and the output
// register; a stalled output holds the block only once the two-entry queue
// fills. The user must write configuration through cfg_we_i/cfg_index_i/
// cfg_data_i while no pixel is in flight; the block does not enforce it.
// depends on tab_pkg, tab_front, tab_queue, tab_back
`default_nettype none

module texture_alpha_blit #(
  parameter int unsigned ADDR_BITS = tab_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] src_pixel_i,
  input  wire logic [31:0] dst_pixel_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [tab_pkg::FB_ADDR_W-1:0] fb_address_o,
  output logic             write_enable_o,
  output logic [31:0]      color_o,
  output logic             last_o
);

  tab_pkg::cfg_t        cfg_q;
  tab_pkg::blit_entry_t wr_entry, rd_entry;
  logic push, pop, q_full, q_not_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width <= tab_pkg::FB_WIDTH_RST;
      cfg_q.tex_x    <= 12'd0;
      cfg_q.tex_y    <= 12'd0;
      cfg_q.tex_w    <= 13'd1;
      cfg_q.tex_h    <= 13'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tab_pkg::CFG_FB_WIDTH: cfg_q.fb_width <= cfg_data_i;
        tab_pkg::CFG_TEX_X:    cfg_q.tex_x    <= cfg_data_i[11:0];
        tab_pkg::CFG_TEX_Y:    cfg_q.tex_y    <= cfg_data_i[11:0];
        tab_pkg::CFG_TEX_W:    cfg_q.tex_w    <= cfg_data_i;
        tab_pkg::CFG_TEX_H:    cfg_q.tex_h    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  tab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .src_pixel_i (src_pixel_i),
    .dst_pixel_i (dst_pixel_i),
    .entry_o     (wr_entry)
  );

  tab_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wr_entry_i  (wr_entry),
    .pop_i       (pop),
    .rd_entry_o  (rd_entry),
    .full_o      (q_full),
    .not_empty_o (q_not_empty)
  );

  tab_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fb_width_i     (cfg_q.fb_width),
    .head_valid_i   (q_not_empty),
    .head_i         (rd_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fb_address_o   (fb_address_o),
    .write_enable_o (write_enable_o),
    .color_o        (color_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ----- src/tab_checker.sv -----
// port-level checker for the texture alpha blit, bound to the top level
// depends on texture_alpha_blit_assert.svh and tab_pkg
`default_nettype none

`include "texture_alpha_blit_assert.svh"

module tab_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [tab_pkg::FB_ADDR_W-1:0] fb_address_o,
  input wire logic        write_enable_o,
  input wire logic [31:0] color_o,
  input wire logic        last_o
);

  logic [tab_pkg::FB_ADDR_W+33:0] out_word;
  logic                           out_opaque;

  // whole result payload and its alpha check
  assign out_word   = {fb_address_o, write_enable_o, color_o, last_o};
  assign out_opaque = color_o[31:24] == tab_pkg::ALPHA_FULL;

  // stalled result stays offered
  `TAB_ASSERT_NX(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "valid dropped under stall")

  // stalled result payload is frozen
  `TAB_ASSERT_NX(a_out_stable, out_valid_o && out_stall_i, $stable(out_word), "payload changed")

  // a skipped pixel carries a zero colour
  `TAB_ASSERT(a_skip_zero, out_valid_o && !write_enable_o, color_o == 32'd0, "skip not zero")

  // every written pixel is opaque
  `TAB_ASSERT(a_write_opaque, out_valid_o && write_enable_o, out_opaque, "pixel not opaque")

endmodule

bind texture_alpha_blit tab_checker u_tab_checker (.*);

`default_nettype wire

// ----- verif/texture_alpha_blit_checker.sv -----
// scoreboard for the texture alpha blit: watches the register port and both pixel channels,
// predicts every frame buffer write and compares it with what the block produces
// depends on tab_pkg
module texture_alpha_blit_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [12:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic [31:0]          src_pixel_i,
  input  wire logic [31:0]          dst_pixel_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic [tab_pkg::FB_ADDR_W-1:0] fb_address_i,
  input  wire logic                 write_enable_i,
  input  wire logic [31:0]          color_i,
  input  wire logic                 last_i,
  output int                        pending_o,
  output int                        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted frame buffer write
  typedef struct packed {
    logic [tab_pkg::FB_ADDR_W-1:0] addr;
    logic                          wr;
    logic [31:0]                   color;
    logic                          last;
  } fb_write_t;

  tab_pkg::cfg_t regs;
  logic [11:0]   col_q;
  logic [11:0]   row_q;
  fb_write_t     writes_due[$];
  fb_write_t     head;
  int            backlog = 0;
  int            fail_count = 0;

  assign pending_o = backlog;
  assign errors_o  = fail_count;

  // texture side as the block sees it: zero means one, clamped at the maximum
  function automatic logic [12:0] side_len(input logic [12:0] v);
    if (v == '0) return 13'd1;
    if (v > tab_pkg::TEX_MAX) return tab_pkg::TEX_MAX;
    return v;
  endfunction

  // one colour channel, source over destination, truncated
  function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                             input logic [7:0] a);
    int unsigned num;
    num = s * a + d * (tab_pkg::ALPHA_FULL - a);
    return 8'(num / tab_pkg::ALPHA_FULL);
  endfunction

  // expected write for one pixel; walks the rectangle counters as a side effect
  function automatic fb_write_t composite_pixel(input logic [31:0] src, input logic [31:0] dst);
    fb_write_t          w;
    logic [12:0]        span_w;
    logic [12:0]        span_h;
    logic [7:0]         a;
    tab_pkg::pix_kind_e kind;
    logic               end_col;
    logic               end_row;
    longint unsigned    line_no;
    longint unsigned    addr;
    span_w  = side_len(regs.tex_w);
    span_h  = side_len(regs.tex_h);
    a       = src[31:24];
    end_col = {1'b0, col_q} >= span_w - 13'd1;
    end_row = {1'b0, row_q} >= span_h - 13'd1;
    line_no = regs.tex_y + row_q;
    addr    = line_no * regs.fb_width + regs.tex_x + col_q;
    w.addr  = addr[tab_pkg::FB_ADDR_W-1:0];
    w.last  = end_col && end_row;

    if (a == '0) kind = tab_pkg::PIX_SKIP;
    else if (a == tab_pkg::ALPHA_FULL) kind = tab_pkg::PIX_COPY;
    else kind = tab_pkg::PIX_BLEND;

    case (kind)
      tab_pkg::PIX_SKIP: begin
        w.wr    = 1'b0;
        w.color = '0;
      end
      tab_pkg::PIX_COPY: begin
        w.wr    = 1'b1;
        w.color = src;
      end
      default: begin
        w.wr    = 1'b1;
        w.color = {tab_pkg::ALPHA_FULL, mix_channel(src[23:16], dst[23:16], a),
                   mix_channel(src[15:8], dst[15:8], a), mix_channel(src[7:0], dst[7:0], a)};
      end
    endcase

    // raster walk, wrapping to the top left corner after the last pixel
    if (end_col) begin
      col_q = '0;
      row_q = end_row ? '0 : row_q + 12'd1;
    end else begin
      col_q = col_q + 12'd1;
    end
    return w;
  endfunction

  // register shadow, prediction on input transfers, comparison on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.fb_width = tab_pkg::FB_WIDTH_RST;
      regs.tex_x    = '0;
      regs.tex_y    = '0;
      regs.tex_w    = 13'd1;
      regs.tex_h    = 13'd1;
      col_q         = '0;
      row_q         = '0;
      writes_due.delete();
      backlog       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tab_pkg::CFG_FB_WIDTH: regs.fb_width = cfg_data_i;
          tab_pkg::CFG_TEX_X:    regs.tex_x    = cfg_data_i[11:0];
          tab_pkg::CFG_TEX_Y:    regs.tex_y    = cfg_data_i[11:0];
          tab_pkg::CFG_TEX_W:    regs.tex_w    = cfg_data_i;
          tab_pkg::CFG_TEX_H:    regs.tex_h    = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        writes_due.push_back(composite_pixel(src_pixel_i, dst_pixel_i));
        backlog++;
      end

      if (out_valid_i && !out_stall_i) begin
        if (writes_due.size() == 0) begin
          $display("%0t: write transfer with none expected: addr %h we %b color %h last %b",
                   $time, fb_address_i, write_enable_i, color_i, last_i);
          fail_count++;
        end else begin
          head = writes_due.pop_front();
          backlog--;
          if (fb_address_i !== head.addr) begin
            $display("%0t: fb_address expected %h got %h", $time, head.addr, fb_address_i);
            fail_count++;
          end
          if (write_enable_i !== head.wr) begin
            $display("%0t: write_enable expected %b got %b", $time, head.wr, write_enable_i);
            fail_count++;
          end
          if (color_i !== head.color) begin
            $display("%0t: color expected %h got %h", $time, head.color, color_i);
            fail_count++;
          end
          if (last_i !== head.last) begin
            $display("%0t: last expected %b got %b", $time, head.last, last_i);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// top of the texture alpha blit testbench: clock, reset, register set-up and pixel stimulus
// with random idling on both channels; the verdict comes from the checker's failure count
// depends on tab_pkg, texture_alpha_blit and texture_alpha_blit_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes past the end of the list, which the block ignores
  localparam logic [2:0] CFG_SPARE_FIRST = tab_pkg::CFG_TEX_H + 3'd1;
  localparam logic [2:0] CFG_SPARE_LAST  = 3'd7;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [12:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          src_pixel = '0;
  logic [31:0]          dst_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [tab_pkg::FB_ADDR_W-1:0] fb_address;
  logic                 write_enable;
  logic [31:0]          color;
  logic                 last_flag;
  logic                 steady = 1'b0;
  int                   pending;
  int                   errors;

  texture_alpha_blit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .src_pixel_i    (src_pixel),
    .dst_pixel_i    (dst_pixel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .fb_address_o   (fb_address),
    .write_enable_o (write_enable),
    .color_o        (color),
    .last_o         (last_flag)
  );

  texture_alpha_blit_checker blit_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .src_pixel_i    (src_pixel),
    .dst_pixel_i    (dst_pixel),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .fb_address_i   (fb_address),
    .write_enable_i (write_enable),
    .color_i        (color),
    .last_i         (last_flag),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // write sink back-pressure, switched off during the steady stretch
  always @(posedge clk_i) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 34);
  end

  // overall run limit
  initial begin
    #4_000_000;
    $display("** texture_alpha_blit: FAILED **");
    $finish;
  end

  // one register write, one cycle wide
  task automatic cfg_write(input logic [2:0] idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // one pixel transfer, after a random number of idle cycles
  task automatic push_pixel(input logic [31:0] src, input logic [31:0] dst);
    bit stalled;
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    src_pixel <= src;
    dst_pixel <= dst;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // hold off until every predicted write has come out
  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // source pixel with the alpha corners well represented
  function automatic logic [31:0] pick_src();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[31:24] = '0;
      1: v[31:24] = tab_pkg::ALPHA_FULL;
      2: v[31:24] = $urandom_range(0, 1) ? 8'd1 : 8'd254;
      default: ;
    endcase
    return v;
  endfunction

  // texture side: mostly small rectangles so that wrap and last come often
  function automatic logic [12:0] pick_side();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return tab_pkg::TEX_MAX;
      2: return 13'h1FFF;
      3: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, 9));
    endcase
  endfunction

  // fresh placement of the texture in the frame buffer
  task automatic program_random();
    logic [12:0] fbw;
    logic [12:0] x;
    logic [12:0] y;
    case ($urandom_range(0, 7))
      0: fbw = '0;
      1: fbw = 13'd1;
      2: fbw = 13'd4096;
      3: fbw = 13'h1FFF;
      4: fbw = 13'($urandom);
      default: fbw = 13'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 3))
      0: x = '0;
      1: x = 13'h1FFF;
      default: x = 13'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: y = '0;
      1: y = 13'h1FFF;
      default: y = 13'($urandom);
    endcase
    cfg_write(tab_pkg::CFG_FB_WIDTH, fbw);
    cfg_write(tab_pkg::CFG_TEX_X, x);
    cfg_write(tab_pkg::CFG_TEX_Y, y);
    cfg_write(tab_pkg::CFG_TEX_W, pick_side());
    cfg_write(tab_pkg::CFG_TEX_H, pick_side());
    if ($urandom_range(0, 3) == 0)
      cfg_write(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 13'($urandom));
  endtask

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned count;
    int          phase;
    int          k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // alpha corners with the reset placement: every pixel is the last one
    push_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF);
    push_pixel(32'hFF12_3456, 32'h0000_0000);
    push_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pixel(32'h01FF_FFFF, 32'h0000_0000);
    push_pixel(32'hFE00_0000, 32'h00FF_FFFF);
    push_pixel(32'h80FF_00FF, 32'hFF00_FF00);
    push_pixel(32'h0000_0000, 32'h0000_0000);
    push_pixel(32'h7FAA_55AA, 32'h1255_AA55);
    in_valid <= 1'b0;
    wait_drained();

    // far corner of the widest frame buffer, address wraps
    cfg_write(tab_pkg::CFG_FB_WIDTH, 13'h1FFF);
    cfg_write(tab_pkg::CFG_TEX_X, 13'h1FFF);
    cfg_write(tab_pkg::CFG_TEX_Y, 13'h0FFF);
    cfg_write(tab_pkg::CFG_TEX_W, 13'd3);
    cfg_write(tab_pkg::CFG_TEX_H, 13'd2);
    repeat (6) push_pixel(pick_src(), $urandom);
    in_valid <= 1'b0;
    wait_drained();

    // zero frame buffer width and zero texture sides, plus ignored indexes
    cfg_write(tab_pkg::CFG_FB_WIDTH, '0);
    cfg_write(tab_pkg::CFG_TEX_W, '0);
    cfg_write(tab_pkg::CFG_TEX_H, '0);
    for (k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++)
      cfg_write(k[2:0], 13'($urandom));
    repeat (2) push_pixel(pick_src(), $urandom);
    in_valid <= 1'b0;
    wait_drained();

    // oversized texture, then shrunk below the current column
    cfg_write(tab_pkg::CFG_FB_WIDTH, 13'd4096);
    cfg_write(tab_pkg::CFG_TEX_X, '0);
    cfg_write(tab_pkg::CFG_TEX_Y, '0);
    cfg_write(tab_pkg::CFG_TEX_W, 13'h1FFF);
    cfg_write(tab_pkg::CFG_TEX_H, 13'h1FFF);
    repeat (5) push_pixel(pick_src(), $urandom);
    in_valid <= 1'b0;
    wait_drained();
    cfg_write(tab_pkg::CFG_TEX_W, 13'd2);
    cfg_write(tab_pkg::CFG_TEX_H, 13'd1);
    repeat (2) push_pixel(pick_src(), $urandom);
    in_valid <= 1'b0;
    wait_drained();

    // random placements, each followed by a burst of pixels; counters carry over
    sent  = 0;
    phase = 0;
    while (sent < 900) begin
      steady <= (phase >= 8) && (phase < 13);
      program_random();
      count = $urandom_range(8, 48);
      repeat (count) push_pixel(pick_src(), $urandom);
      in_valid <= 1'b0;
      sent += count;
      phase++;
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("** texture_alpha_blit: PASSED **");
    else
      $display("** texture_alpha_blit: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/tab_pkg.sv
src/tab_front.sv
src/tab_queue.sv
src/tab_back.sv
src/texture_alpha_blit.sv
src/tab_checker.sv
verif/texture_alpha_blit_checker.sv
verif/testbench.sv
